FILE: hdl/irf_pkg.sv
// irf_pkg: shared constants and types for the integer radix formatter
// no dependencies; imported by every module of the block

package irf_pkg;

    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // dividend bits retired per divider cycle
    localparam int STEP_BITS  = 8;

    localparam logic [CHAR_W-1:0] SIGN_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR = 8'h2B;
    localparam logic [CHAR_W-1:0] NUL_CHAR  = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef struct packed {
        logic done;
        logic quo_zero;
    } t_div_stat;

endpackage

FILE: hdl/irf_alpha_check.sv
// irf_alpha_check: decides whether the configured radix and alphabet are usable
// depends on irf_pkg

module irf_alpha_check #(
    parameter int MAX_RADIX = 16
) (
    input  logic [irf_pkg::RADIX_W-1:0]          i_radix,
    input  logic [MAX_RADIX*irf_pkg::CHAR_W-1:0] i_symbols,
    output logic                                 o_valid
);
    import irf_pkg::*;

    logic [CHAR_W-1:0] sym [MAX_RADIX];
    logic              bad;

    always_comb begin
        for (int k = 0; k < MAX_RADIX; k++) begin
            sym[k] = i_symbols[k*CHAR_W +: CHAR_W];
        end
    end

    // every check is independent; any failing one marks the alphabet bad
    always_comb begin
        bad = 1'b0;
        for (int a = 0; a < MAX_RADIX; a++) begin
            if (RADIX_W'(a) < i_radix) begin
                if (sym[a] == NUL_CHAR || sym[a] == SIGN_CHAR || sym[a] == PLUS_CHAR) begin
                    bad = 1'b1;
                end
                for (int b = a + 1; b < MAX_RADIX; b++) begin
                    if (RADIX_W'(b) < i_radix && sym[a] == sym[b]) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign o_valid = !bad && (i_radix >= RADIX_W'(2)) && (i_radix <= RADIX_W'(MAX_RADIX));

endmodule

FILE: hdl/irf_divider.sv
// irf_divider: iterative divide of a magnitude by the radix, STEP_BITS bits a cycle
// depends on irf_pkg

module irf_divider #(
    parameter int PAD_W = 40,
    parameter int DIG_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [PAD_W-1:0]            i_dividend,
    input  logic [irf_pkg::RADIX_W-1:0] i_base,
    output irf_pkg::t_div_stat          o_stat,
    output logic [PAD_W-1:0]            o_quotient,
    output logic [DIG_W-1:0]            o_remainder
);
    import irf_pkg::*;

    localparam int CHUNKS = PAD_W / STEP_BITS;
    localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CW     = (DIG_W + 1 > RADIX_W) ? DIG_W + 1 : RADIX_W;

    logic [PAD_W-1:0] r_work, n_work;
    logic [DIG_W-1:0] r_rem,  n_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // one restoring step per dividend bit, STEP_BITS of them per cycle
    always_comb begin
        logic [DIG_W:0] t;
        logic [CW-1:0]  t_ext;
        logic [CW-1:0]  b_ext;
        logic [CW-1:0]  diff;
        n_work = r_work;
        n_rem  = r_rem;
        b_ext  = CW'(i_base);
        for (int j = 0; j < STEP_BITS; j++) begin
            t      = {n_rem, n_work[PAD_W-1]};
            n_work = {n_work[PAD_W-2:0], 1'b0};
            t_ext  = CW'(t);
            diff   = t_ext - b_ext;
            if (t_ext >= b_ext) begin
                n_work[0] = 1'b1;
                n_rem     = diff[DIG_W-1:0];
            end else begin
                n_rem     = t[DIG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(CHUNKS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quo_zero = (r_work == '0);
    assign o_quotient      = r_work;
    assign o_remainder     = r_rem;

endmodule

FILE: hdl/integer_radix_formatter.sv
// integer_radix_formatter: signed integer to radix text, one character per transaction
// depends on irf_pkg, irf_alpha_check, irf_divider
// each digit is one run of the shared divider, on a dividend padded to whole STEP_BITS
// chunks, and a negative value gets a sign character before its digits; output stalls
// hold back the characters and so the next value;
// input stalls from acceptance until the last character is loaded, an invalid alphabet
// drops values with no stall; sync reset clears control and config registers, so the
// alphabet is invalid and every value is dropped until configured

module integer_radix_formatter #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [irf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [VALUE_BITS-1:0]   i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [irf_pkg::CHAR_W-1:0]     o_character,
    output logic                           o_last
);
    import irf_pkg::*;

    localparam int MAG_W  = VALUE_BITS + 1;
    localparam int CHUNKS = (MAG_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = CHUNKS * STEP_BITS;
    localparam int DIG_W  = $clog2(MAX_RADIX);
    localparam int NSYM   = 2 ** DIG_W;
    localparam int DEPTH  = VALUE_BITS + 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [RADIX_W-1:0]    r_radix;
    logic [CFG_DATA_W-1:0] r_sym_low;
    logic [CFG_DATA_W-1:0] r_sym_high;

    logic [DIG_W-1:0]  r_stack [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic              r_sign_pend;
    logic              r_ovalid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic [2*CFG_DATA_W-1:0] sym_all;
    logic [CHAR_W-1:0]       sym [NSYM];
    logic                    alpha_ok;
    logic                    accept;
    logic                    div_start;
    logic [PAD_W-1:0]        div_dividend;
    logic [PAD_W-1:0]        quotient;
    logic [DIG_W-1:0]        remainder;
    t_div_stat               div_stat;
    logic [MAG_W-1:0]        val_ext;
    logic [MAG_W-1:0]        mag;
    logic                    push;
    logic                    pop;
    logic                    load_sign;
    logic                    out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= '0;
            r_sym_low  <= '0;
            r_sym_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RADIX:        r_radix    <= i_cfg_data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  r_sym_low  <= i_cfg_data;
                REG_SYMBOLS_HIGH: r_sym_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sym_all = {r_sym_high, r_sym_low};

    always_comb begin
        for (int k = 0; k < NSYM; k++) begin
            sym[k] = sym_all[k*CHAR_W +: CHAR_W];
        end
    end

    irf_alpha_check #(
        .MAX_RADIX(MAX_RADIX)
    ) u_alpha (
        .i_radix  (r_radix),
        .i_symbols(sym_all[MAX_RADIX*CHAR_W-1:0]),
        .o_valid  (alpha_ok)
    );

    // magnitude at one extra bit so the most negative value stays exact
    assign val_ext = {i_value[VALUE_BITS-1], i_value};
    assign mag     = i_value[VALUE_BITS-1] ? (~val_ext + MAG_W'(1)) : val_ext;

    assign accept       = i_valid && (r_state == S_IDLE);
    assign o_stall      = (r_state != S_IDLE);
    assign push         = (r_state == S_DIV) && div_stat.done;
    assign div_start    = (accept && alpha_ok) || (push && !div_stat.quo_zero);
    assign div_dividend = (r_state == S_IDLE) ? PAD_W'(mag) : quotient;

    irf_divider #(
        .PAD_W(PAD_W),
        .DIG_W(DIG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_base     (r_radix),
        .o_stat     (div_stat),
        .o_quotient (quotient),
        .o_remainder(remainder)
    );

    assign out_free  = !r_ovalid || !i_stall;
    assign load_sign = (r_state == S_EMIT) && out_free && r_sign_pend;
    assign pop       = (r_state == S_EMIT) && out_free && !r_sign_pend;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && alpha_ok) n_state = S_DIV;
            S_DIV:  if (push && div_stat.quo_zero) n_state = S_EMIT;
            S_EMIT: if (pop && r_count == CNT_W'(1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sign_pend <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count     <= '0;
                r_sign_pend <= i_value[VALUE_BITS-1];
            end else if (push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (load_sign) begin
                r_sign_pend <= 1'b0;
            end
            if (load_sign || pop) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // digit stack: newest digit (most significant so far) sits at the top
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[0] <= remainder;
            for (int k = 1; k < DEPTH; k++) begin
                r_stack[k] <= r_stack[k-1];
            end
        end else if (pop) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                r_stack[k] <= r_stack[k+1];
            end
            r_stack[DEPTH-1] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_sign) begin
            r_char <= SIGN_CHAR;
            r_last <= 1'b0;
        end else if (pop) begin
            r_char <= sym[r_stack[0]];
            r_last <= (r_count == CNT_W'(1));
        end
    end

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

FILE: tb/irf_checker.sv
// irf_checker: watches the value and character channels of integer_radix_formatter,
// predicts the text of every accepted value and compares it character by character
// depends on irf_pkg
`timescale 1ns / 100ps

module irf_checker #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [irf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [VALUE_BITS-1:0]          i_in_value,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [irf_pkg::CHAR_W-1:0]     i_out_character,
    input  logic                           i_out_last,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_value_count,
    output int                             o_char_count
);
    import irf_pkg::*;

    localparam int REPORT_LINES = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    logic [RADIX_W-1:0] radix_r;
    logic [127:0]       alphabet_r;
    t_text_char         text_q[$];
    t_text_char         want;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < REPORT_LINES)
            $display("%0t ns  mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic bit alphabet_ok();
        int n;
        int a;
        int b;
        logic [CHAR_W-1:0] s;
        n = radix_r;
        if (n < 2 || n > MAX_RADIX)
            return 1'b0;
        for (a = 0; a < n; a++) begin
            s = alphabet_r[8*a +: 8];
            if (s == NUL_CHAR || s == SIGN_CHAR || s == PLUS_CHAR)
                return 1'b0;
            for (b = a + 1; b < n; b++)
                if (alphabet_r[8*b +: 8] == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // digits are formed from a magnitude one bit wider than the value
    task automatic queue_text(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS:0] mag;
        logic [VALUE_BITS:0] base;
        int unsigned digits[$];
        int k;
        if (!alphabet_ok())
            return;
        base = radix_r;
        mag = v[VALUE_BITS-1] ? {1'b0, ~v} + 1'b1 : {1'b0, v};
        do begin
            digits.push_front(int'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        if (v[VALUE_BITS-1])
            text_q.push_back('{ch: SIGN_CHAR, last: 1'b0});
        for (k = 0; k < digits.size(); k++)
            text_q.push_back('{ch: alphabet_r[8*digits[k] +: 8],
                               last: (k == digits.size() - 1)});
    endtask

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_value_count = 0;
        o_char_count  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_r    = '0;
            alphabet_r = '0;
            text_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (text_q.size() == 0) begin
                    report_mismatch($sformatf("character %02h last %0b with nothing expected",
                                              i_out_character, i_out_last));
                end else begin
                    want = text_q.pop_front();
                    if (i_out_character !== want.ch)
                        report_mismatch($sformatf("character %02h, expected %02h",
                                                  i_out_character, want.ch));
                    if (i_out_last !== want.last)
                        report_mismatch($sformatf("last %0b on character %02h, expected %0b",
                                                  i_out_last, want.ch, want.last));
                    o_char_count++;
                end
            end
            // writes must land only while the block is idle (not enforced by it), so order against items is moot
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RADIX:        radix_r = i_cfg_data[RADIX_W-1:0];
                    REG_SYMBOLS_LOW:  alphabet_r[63:0] = i_cfg_data;
                    REG_SYMBOLS_HIGH: alphabet_r[127:64] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                queue_text(i_in_value);
                o_value_count++;
            end
        end
        o_pending = text_q.size();
    end

endmodule

FILE: tb/tb.sv
// tb: top of the integer_radix_formatter testbench; drives configuration and values,
// stalls the character channel at random and gives the verdict
// depends on irf_pkg, integer_radix_formatter and irf_checker
`timescale 1ns / 100ps

module tb;
    import irf_pkg::*;

    localparam int MAX_RADIX     = 16;
    localparam int VALUE_BITS    = 32;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_VALUES  = 25;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data  = '0;
    logic                         i_valid     = 1'b0;
    logic signed [VALUE_BITS-1:0] i_value     = '0;
    logic                         i_stall     = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic [CHAR_W-1:0]            o_character;
    logic                         o_last;

    int fail_count;
    int pending;
    int value_count;
    int char_count;
    int settings_count = 0;
    bit quiet = 1'b0;

    integer_radix_formatter #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    irf_checker #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_value      (i_value),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_character (o_character),
        .i_out_last      (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_value_count   (value_count),
        .o_char_count    (char_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 17);
    endfunction

    always @(posedge i_clk) begin
        i_stall <= idle_now();
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // radix upper bits carry random junk, only the low five bits count
    task automatic set_alphabet(input int n, input logic [127:0] syms);
        logic [CFG_DATA_W-1:0] word;
        word = {$urandom, $urandom};
        word[RADIX_W-1:0] = n[RADIX_W-1:0];
        write_reg(REG_RADIX, word);
        write_reg(REG_SYMBOLS_LOW, syms[63:0]);
        write_reg(REG_SYMBOLS_HIGH, syms[127:64]);
    endtask

    // called at a clock edge; returns at the edge where the value is taken
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        if (idle_now()) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (idle_now());
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic finish_phase();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        // values dropped by a bad alphabet leave nothing to wait on, so give them time
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        settings_count++;
    endtask

    task automatic pick_alphabet(input bit spoil, inout int n, output logic [127:0] syms);
        logic [CHAR_W-1:0] s;
        bit clash;
        int k;
        int j;
        int a;
        int b;
        syms = {$urandom, $urandom, $urandom, $urandom};
        for (k = 0; k < n && k < MAX_RADIX; k++) begin
            do begin
                s = CHAR_W'($urandom_range(255, 1));
                clash = (s == SIGN_CHAR) || (s == PLUS_CHAR);
                for (j = 0; j < k; j++)
                    if (syms[8*j +: 8] == s)
                        clash = 1'b1;
            end while (clash);
            syms[8*k +: 8] = s;
        end
        if (spoil) begin
            case ($urandom_range(4))
                0: begin
                    a = $urandom_range(n - 2, 0);
                    b = $urandom_range(n - 1, a + 1);
                    syms[8*b +: 8] = syms[8*a +: 8];
                end
                1: syms[8*$urandom_range(n - 1) +: 8] = PLUS_CHAR;
                2: syms[8*$urandom_range(n - 1) +: 8] = SIGN_CHAR;
                3: syms[8*$urandom_range(n - 1) +: 8] = NUL_CHAR;
                default: begin
                    k = $urandom_range(16);
                    n = (k < 2) ? k : k + 15;
                end
            endcase
        end
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value(input int n);
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(9))
            5, 6: v = $urandom_range(2 * n * n);
            7: begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = 1;
                    2: v = '1;
                    3: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
                    default: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
                endcase
            end
            8, 9: v = $urandom >> $urandom_range(VALUE_BITS - 1);
            default: v = $urandom;
        endcase
        if ($urandom_range(1) == 1 && v != '0 && $urandom_range(9) > 6)
            v = -v;
        return v;
    endfunction

    initial begin
        logic [127:0] syms;
        int n;
        int ph;
        int k;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset the alphabet is empty: nothing comes out, not even for zero
        send_value(0);
        send_value(-7);
        finish_phase();

        quiet = 1'b1;
        set_alphabet(10, {48'h0, "9876543210"});
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(-10);
        send_value(123456789);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        finish_phase();
        quiet = 1'b0;

        // most negative value in base two gives the longest text
        set_alphabet(2, {112'h0, "10"});
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(0);
        finish_phase();

        for (k = 0; k < MAX_RADIX; k++)
            syms[8*k +: 8] = 8'hFF - k;
        set_alphabet(16, syms);
        send_value(32'h8000_0000);
        send_value(255);
        send_value(-256);
        finish_phase();

        // broken alphabets and out of range radix values
        set_alphabet(17, syms);
        send_value(0);
        finish_phase();
        set_alphabet(31, syms);
        send_value(-1);
        finish_phase();
        set_alphabet(1, syms);
        send_value(0);
        finish_phase();
        set_alphabet(10, {48'h0, "9876543211"});
        send_value(0);
        finish_phase();
        set_alphabet(10, {48'h0, "98765432+0"});
        send_value(42);
        finish_phase();
        set_alphabet(2, {112'h0, "-1"});
        send_value(-3);
        finish_phase();
        set_alphabet(3, {104'h0, 8'h00, "10"});
        send_value(0);
        finish_phase();

        // bytes past the radix are never looked at; a write to the spare index changes nothing
        set_alphabet(3, {64'h0, "-+", 8'h00, "ba0"});
        write_reg(REG_UNUSED, {$urandom, $urandom});
        send_value(-5);
        send_value(80);
        finish_phase();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet = (ph == 4);
            case ($urandom_range(4))
                0: n = 2;
                1: n = MAX_RADIX;
                default: n = $urandom_range(MAX_RADIX - 1, 3);
            endcase
            pick_alphabet($urandom_range(99) < 15, n, syms);
            set_alphabet(n, syms);
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            for (k = 0; k < PHASE_VALUES; k++)
                send_value(random_value((n >= 2 && n <= MAX_RADIX) ? n : 10));
            finish_phase();
        end
        quiet = 1'b0;

        $display("sent %0d values under %0d alphabet settings, %0d characters compared",
                 value_count, settings_count, char_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("run did not finish in time, %0d characters still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: integer_radix_formatter.f
hdl/irf_pkg.sv
hdl/irf_alpha_check.sv
hdl/irf_divider.sv
hdl/integer_radix_formatter.sv
tb/irf_checker.sv
tb/tb.sv
